/* rtl/modexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

   localparam int unsigned MOD_W      = 31;
   localparam int unsigned BASE_W     = 32;
   localparam int unsigned EXP_W      = 32;
   localparam int unsigned SCAN_W     = 32;
   localparam int unsigned CNT_W      = 6;

   localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
   localparam logic [CNT_W-1:0] CNT_LAST      = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_DONE
   } state_type;

endpackage

/* rtl/modular_exponentiation_top.sv */
// Modular exponentiation top level: base to the power exponent modulo a register.
//
// One item is worked at a time. After the transfer the base is reduced modulo the
// modulus, then each exponent bit up to the highest set one is worked in turn, and
// the result is handed to the output register. The bit-serial modular multiplier
// works through each of the 32 bits of its scanned operand with a modular doubling,
// then a conditional modular add. Two lanes share the scan, so the accumulator
// product and the base square of one exponent bit are formed together. A zero
// modulus gives 0 at once; an exponent of zero gives 1. The modulus register is
// written only while no item is in work; a result waiting in the output register
// does not hold back the next input transfer.
module modular_exponentiation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] base_value, [63:32] exponent
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] power_result, [31] zero
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [31:0] csr_tdata    // [30:0] modulus, [31] zero
);
   import modexp_pkg::*;

   state_type           state_ff, state_in;
   logic [MOD_W-1:0]    mod_ff, mod_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SCAN_W-1:0]   op_ff, op_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [MOD_W-1:0]    acc_ff, acc_in;
   logic [MOD_W-1:0]    b_ff, b_in;
   logic [MOD_W-1:0]    r0_ff, r0_in;
   logic [MOD_W-1:0]    r1_ff, r1_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [MOD_W-1:0]    a0, a1;
   logic [MOD_W-1:0]    r0_next, r1_next;
   logic [MOD_W-1:0]    one_mod;
   logic                scan_bit;
   logic                phase;
   logic                req_xfer;
   logic                csr_xfer;

   // One step of a bit-serial modular multiply: phase 0 doubles the partial
   // result, phase 1 adds the multiplicand when the scanned bit is set. The
   // partial result stays below the modulus, so one subtraction suffices.
   function automatic logic [MOD_W-1:0] lane_next(
      input logic [MOD_W-1:0] r,
      input logic [MOD_W-1:0] a,
      input logic [MOD_W-1:0] m,
      input logic             ph,
      input logic             bit_set
   );
      logic [MOD_W:0] sum;
      logic [MOD_W:0] dif;
      begin
         if (!ph) begin
            sum = {r, 1'b0};
         end else if (bit_set) begin
            sum = {1'b0, r} + {1'b0, a};
         end else begin
            sum = {1'b0, r};
         end
         dif = sum - {1'b0, m};
         if (sum >= {1'b0, m}) begin
            lane_next = dif[MOD_W-1:0];
         end else begin
            lane_next = sum[MOD_W-1:0];
         end
      end
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_tvalid && csr_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   assign phase    = cnt_ff[0];
   assign scan_bit = op_ff[SCAN_W-1];
   // One reduced modulo the modulus: zero only when the modulus is one.
   assign one_mod  = (mod_ff == {{(MOD_W-1){1'b0}}, 1'b1}) ? '0 : {{(MOD_W-1){1'b0}}, 1'b1};

   // While the base is reduced, lane 0 folds in the base bits and lane 1 idles.
   assign a0 = (state_ff == ST_REDUCE) ? one_mod : acc_ff;
   assign a1 = (state_ff == ST_REDUCE) ? '0 : b_ff;

   assign r0_next = lane_next(r0_ff, a0, mod_ff, phase, scan_bit);
   assign r1_next = lane_next(r1_ff, a1, mod_ff, phase, scan_bit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= MODULUS_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      b_ff        <= b_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_xfer) begin
         mod_in = csr_tdata[MOD_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in  = req_tdata[BASE_W-1:0];
               exp_in = req_tdata[BASE_W+EXP_W-1:BASE_W];
               cnt_in = '0;
               r0_in  = '0;
               r1_in  = '0;
               if (mod_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  acc_in   = {{(MOD_W-1){1'b0}}, 1'b1};
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            r0_in  = r0_next;
            r1_in  = r1_next;
            cnt_in = cnt_ff + 1'b1;
            if (phase) begin
               op_in = {op_ff[SCAN_W-2:0], 1'b0};
            end
            if (cnt_ff == CNT_LAST) begin
               b_in  = r0_next;
               op_in = {1'b0, r0_next};
               r0_in = '0;
               r1_in = '0;
               if (exp_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            r0_in  = r0_next;
            r1_in  = r1_next;
            cnt_in = cnt_ff + 1'b1;
            if (phase) begin
               op_in = {op_ff[SCAN_W-2:0], 1'b0};
            end
            if (cnt_ff == CNT_LAST) begin
               if (exp_ff[0]) begin
                  acc_in = r0_next;
               end
               b_in   = r1_next;
               op_in  = {1'b0, r1_next};
               exp_in = {1'b0, exp_ff[EXP_W-1:1]};
               r0_in  = '0;
               r1_in  = '0;
               if (exp_ff[EXP_W-1:1] == '0) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_lanes_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE || state_ff == ST_STEP) |-> (r0_ff < mod_ff && r1_ff < mod_ff))
      else $error("partial product not below the modulus");

   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (b_ff < mod_ff && exp_ff != '0))
      else $error("step entered with unreduced base or spent exponent");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE))
      else $error("result dropped while the output register was full");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=>
         (rsp_valid_ff && rsp_data_ff == $past(acc_ff)))
      else $error("result not loaded into the output register");
`endif

endmodule
